FILE: hdl/tbcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbcp_pkg
// Shared types, constants and the TEA mixing function for the padded cipher.
// ----------------------------------------------------------------------------
package tbcp_pkg;

    localparam int unsigned ROUND_COUNT = 32;
    localparam logic [31:0] TEA_DELTA   = 32'h9e3779b9;
    localparam logic [31:0] DEC_SUM     = 32'(64'(ROUND_COUNT) * 64'(TEA_DELTA));
    localparam logic [3:0]  BLOCK_BYTES = 4'd8;
    localparam logic [31:0] PAD_WORD    = 32'h08080808;

    typedef enum logic [1:0] {
        CFG_KEY0 = 2'd0,
        CFG_KEY1 = 2'd1,
        CFG_KEY2 = 2'd2,
        CFG_KEY3 = 2'd3
    } t_cfg_reg;

    typedef enum logic {
        CMD_ENCRYPT = 1'b0,
        CMD_DECRYPT = 1'b1
    } t_cmd;

    typedef struct packed {
        logic        command;
        logic [31:0] block_low;
        logic [31:0] block_high;
        logic [3:0]  byte_count;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [31:0] out_low;
        logic [31:0] out_high;
        logic [3:0]  kept_bytes;
        logic        pad_error;
        logic        final_result;
    } t_out_item;

    typedef struct packed {
        logic [31:0] k0;
        logic [31:0] k1;
        logic [31:0] k2;
        logic [31:0] k3;
    } t_key;

    // One word of work travelling down the cell chain
    typedef struct packed {
        logic        valid;
        logic        dec;
        logic        last;
        logic        fin;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] s;
    } t_lane;

    typedef struct packed {
        logic [3:0] kept;
        logic       err;
    } t_unpad;

    function automatic logic [31:0] tbcp_mix(input logic [31:0] v, input logic [31:0] s,
                                             input logic [31:0] kx, input logic [31:0] ky);
        tbcp_mix = ((v << 4) + kx) ^ (v + s) ^ ((v >> 5) + ky);
    endfunction

endpackage

FILE: hdl/tbcp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbcp_cell
// One TEA cycle (two half rounds), encrypt or decrypt, registered output.
// ----------------------------------------------------------------------------
module tbcp_cell import tbcp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_key  i_key,
    input  t_lane i_lane,
    output t_lane o_lane
);

    logic        r_valid;
    t_lane       r_data;
    t_lane       n_data;
    logic [31:0] enc_a;
    logic [31:0] enc_b;
    logic [31:0] dec_a;
    logic [31:0] dec_b;

    always_comb begin
        enc_a = i_lane.a + tbcp_mix(i_lane.b, i_lane.s, i_key.k0, i_key.k1);
        enc_b = i_lane.b + tbcp_mix(enc_a, i_lane.s, i_key.k2, i_key.k3);
        dec_b = i_lane.b - tbcp_mix(i_lane.a, i_lane.s, i_key.k2, i_key.k3);
        dec_a = i_lane.a - tbcp_mix(dec_b, i_lane.s, i_key.k0, i_key.k1);
        n_data = i_lane;
        if (i_lane.dec == CMD_DECRYPT) begin
            n_data.a = dec_a;
            n_data.b = dec_b;
            n_data.s = i_lane.s - TEA_DELTA;
        end else begin
            n_data.a = enc_a;
            n_data.b = enc_b;
            n_data.s = i_lane.s + TEA_DELTA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_lane.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    always_comb begin
        o_lane       = r_data;
        o_lane.valid = r_valid;
    end

endmodule

FILE: hdl/tbcp_unpad.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbcp_unpad
// Checks and measures the pad of a decrypted last block.
// ----------------------------------------------------------------------------
module tbcp_unpad import tbcp_pkg::*; (
    input  t_lane  i_lane,
    output t_unpad o_unpad
);

    logic [7:0]  pad;
    logic [63:0] blk;
    logic        bad;

    always_comb begin
        blk = {i_lane.b, i_lane.a};
        pad = i_lane.b[31:24];
        bad = pad > 8'(BLOCK_BYTES);
        for (int k = 0; k < 7; k++) begin
            if ((9'(k) + 9'(pad) >= 9'(BLOCK_BYTES)) && (blk[8*k +: 8] != pad)) begin
                bad = 1'b1;
            end
        end
        if (i_lane.dec == CMD_DECRYPT && i_lane.last) begin
            o_unpad.err  = bad;
            o_unpad.kept = bad ? 4'd0 : BLOCK_BYTES - pad[3:0];
        end else begin
            o_unpad.err  = 1'b0;
            o_unpad.kept = BLOCK_BYTES;
        end
    end

endmodule

FILE: hdl/tea_block_cipher_padded.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_block_cipher_padded
// TEA block cipher with PKCS#7-style padding, one cell per TEA cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_ready carries one 64-bit block with its
//   command, byte count and last flag. Output channel o_out_valid /
//   i_out_ready returns result blocks with kept byte count, pad error and a
//   final flag. Key words are written through i_cfg_we / i_cfg_index /
//   i_cfg_data while the block is idle; the user ensures it, not the block.
//   A block passes the ROUND_COUNT cells and the output register to o_out_valid.
//   One block is taken every cycle while the chain advances; an encrypt of
//   a full last block then injects the encrypted pad block with input held off.
//   The chain of ROUND_COUNT cells moves as one; it advances whenever its
//   last cell is empty or the output register is free or being read. When
//   the receiver stalls with a result in the last cell, the chain and the
//   input stall together.
//   Reset clears the key words to zero and empties the chain and output.
// ----------------------------------------------------------------------------
module tea_block_cipher_padded import tbcp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_key        r_key;
    logic        r_pad_pending;
    logic        r_out_valid;
    t_out_item   r_out;
    t_lane       lanes [ROUND_COUNT+1];
    t_lane       head_lane;
    t_lane       last_lane;
    t_unpad      unpad;
    logic        advance;
    logic        in_xfer;
    logic        full_last;
    logic [3:0]  cnt_sat;
    logic [63:0] padded;

    assign last_lane  = lanes[ROUND_COUNT];
    assign advance    = !last_lane.valid || !r_out_valid || i_out_ready;
    assign o_in_ready = advance && !r_pad_pending;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign cnt_sat    = (i_in_data.byte_count > BLOCK_BYTES) ? BLOCK_BYTES
                                                             : i_in_data.byte_count;
    assign full_last  = (i_in_data.command == CMD_ENCRYPT) && i_in_data.last
                        && (cnt_sat == BLOCK_BYTES);

    always_comb begin
        padded = {i_in_data.block_high, i_in_data.block_low};
        if (i_in_data.command == CMD_ENCRYPT && i_in_data.last) begin
            for (int k = 0; k < 8; k++) begin
                if (4'(k) >= cnt_sat) begin
                    padded[8*k +: 8] = 8'(BLOCK_BYTES - cnt_sat);
                end
            end
        end
    end

    always_comb begin
        if (r_pad_pending) begin
            head_lane.valid = 1'b1;
            head_lane.dec   = CMD_ENCRYPT;
            head_lane.last  = 1'b0;
            head_lane.fin   = 1'b1;
            head_lane.a     = PAD_WORD;
            head_lane.b     = PAD_WORD;
            head_lane.s     = TEA_DELTA;
        end else begin
            head_lane.valid = in_xfer;
            head_lane.dec   = i_in_data.command;
            head_lane.last  = i_in_data.last;
            head_lane.fin   = !full_last;
            head_lane.a     = padded[31:0];
            head_lane.b     = padded[63:32];
            head_lane.s     = (i_in_data.command == CMD_DECRYPT) ? DEC_SUM : TEA_DELTA;
        end
    end

    assign lanes[0] = head_lane;

    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_cell
        tbcp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (advance),
            .i_key   (r_key),
            .i_lane  (lanes[g]),
            .o_lane  (lanes[g+1])
        );
    end

    tbcp_unpad u_unpad (
        .i_lane  (last_lane),
        .o_unpad (unpad)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY0: r_key.k0 <= i_cfg_data;
                CFG_KEY1: r_key.k1 <= i_cfg_data;
                CFG_KEY2: r_key.k2 <= i_cfg_data;
                CFG_KEY3: r_key.k3 <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_pending <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (r_pad_pending && advance) begin
                r_pad_pending <= 1'b0;
            end else if (in_xfer && full_last) begin
                r_pad_pending <= 1'b1;
            end
            if (advance && last_lane.valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && last_lane.valid) begin
            r_out.out_low      <= last_lane.a;
            r_out.out_high     <= last_lane.b;
            r_out.kept_bytes   <= unpad.kept;
            r_out.pad_error    <= unpad.err;
            r_out.final_result <= last_lane.fin;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_pad_inject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && full_last) |=> !o_in_ready)
        else $error("pad block not injected after full last block");

    a_err_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.pad_error) |-> (o_out_data.kept_bytes == 4'd0))
        else $error("pad error with nonzero kept bytes");

    a_first_of_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.final_result)
        |-> (o_out_data.kept_bytes == BLOCK_BYTES && !o_out_data.pad_error))
        else $error("non-final result with pad status");

endmodule

FILE: tb/tea_block_cipher_padded_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_block_cipher_padded_check
// Scoreboard for the padded TEA cipher: watches both channels and the key
// port, keeps its own copy of the key, computes the result blocks of every
// accepted input block and compares each output transfer, field by field,
// with the oldest pending prediction.
// ----------------------------------------------------------------------------
module tea_block_cipher_padded_check import tbcp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    t_key      cipher_key;
    t_out_item predicted_blocks[$];
    int        mismatches = 0;

    function automatic logic [63:0] tea_encrypt(input logic [63:0] blk, input t_key key);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] s;
        int          r;
        a = blk[31:0];
        b = blk[63:32];
        s = '0;
        for (r = 0; r < ROUND_COUNT; r++) begin
            s = s + TEA_DELTA;
            a = a + (((b << 4) + key.k0) ^ (b + s) ^ ((b >> 5) + key.k1));
            b = b + (((a << 4) + key.k2) ^ (a + s) ^ ((a >> 5) + key.k3));
        end
        return {b, a};
    endfunction

    function automatic logic [63:0] tea_decrypt(input logic [63:0] blk, input t_key key);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] s;
        int          r;
        a = blk[31:0];
        b = blk[63:32];
        s = TEA_DELTA * ROUND_COUNT;
        for (r = 0; r < ROUND_COUNT; r++) begin
            b = b - (((a << 4) + key.k2) ^ (a + s) ^ ((a >> 5) + key.k3));
            a = a - (((b << 4) + key.k0) ^ (b + s) ^ ((b >> 5) + key.k1));
            s = s - TEA_DELTA;
        end
        return {b, a};
    endfunction

    function automatic void predict_cipher_results(input t_in_item item);
        logic [3:0]  count;
        logic [63:0] blk;
        logic [7:0]  pad;
        logic        bad;
        int          k;
        t_out_item   res;
        count = (item.byte_count > BLOCK_BYTES) ? BLOCK_BYTES : item.byte_count;
        blk = {item.block_high, item.block_low};
        res.kept_bytes = BLOCK_BYTES;
        res.pad_error = 1'b0;
        res.final_result = 1'b1;
        if (item.command == CMD_ENCRYPT) begin
            if (item.last && count < BLOCK_BYTES) begin
                for (k = count; k < BLOCK_BYTES; k++) begin
                    blk[8*k +: 8] = 8'(BLOCK_BYTES - count);
                end
            end
            {res.out_high, res.out_low} = tea_encrypt(blk, cipher_key);
            // full last block: extra block of pure padding follows
            if (item.last && count == BLOCK_BYTES) begin
                res.final_result = 1'b0;
                predicted_blocks.push_back(res);
                {res.out_high, res.out_low} = tea_encrypt({2{PAD_WORD}}, cipher_key);
                res.final_result = 1'b1;
            end
        end else begin
            blk = tea_decrypt(blk, cipher_key);
            {res.out_high, res.out_low} = blk;
            if (item.last) begin
                pad = blk[63:56];
                bad = pad > BLOCK_BYTES;
                for (k = 2; k <= BLOCK_BYTES; k++) begin
                    if (!bad && k <= pad && blk[8*(8-k) +: 8] != pad) begin
                        bad = 1'b1;
                    end
                end
                res.pad_error = bad;
                res.kept_bytes = bad ? 4'd0 : BLOCK_BYTES - pad[3:0];
            end
        end
        predicted_blocks.push_back(res);
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            cipher_key = '0;
            predicted_blocks.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                predict_cipher_results(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                if (predicted_blocks.size() == 0) begin
                    $error("unexpected result transfer: out_low %0h out_high %0h",
                           i_out_data.out_low, i_out_data.out_high);
                    mismatches++;
                end else begin
                    want = predicted_blocks.pop_front();
                    check_field("out_low", want.out_low, i_out_data.out_low);
                    check_field("out_high", want.out_high, i_out_data.out_high);
                    check_field("kept_bytes", 32'(want.kept_bytes),
                                32'(i_out_data.kept_bytes));
                    check_field("pad_error", 32'(want.pad_error),
                                32'(i_out_data.pad_error));
                    check_field("final_result", 32'(want.final_result),
                                32'(i_out_data.final_result));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KEY0: cipher_key.k0 = i_cfg_data;
                    CFG_KEY1: cipher_key.k1 = i_cfg_data;
                    CFG_KEY2: cipher_key.k2 = i_cfg_data;
                    CFG_KEY3: cipher_key.k3 = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = predicted_blocks.size();
        o_fail_count = mismatches;
    end

endmodule

FILE: tb/tea_block_cipher_padded_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_block_cipher_padded_test
// Top of the padded TEA cipher testbench. Drives directed corner blocks, then
// random messages over several keys: plaintext messages are encrypted, their
// ciphertexts are fed back for decryption so the padding checks see real
// pads, mixed with crafted pad patterns, broken messages and noise. Both
// channels idle at random; one long output stall fills the pipeline.
// ----------------------------------------------------------------------------
module tea_block_cipher_padded_test;
    import tbcp_pkg::*;

    localparam int WAIT_MAX        = 17;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int SETTLE_CYCLES   = ROUND_COUNT + 8;
    localparam int RANDOM_ITEMS    = 1100;
    localparam int PHASES          = 5;

    typedef struct packed {
        logic keep;
        logic msg_end;
    } t_route;

    typedef struct packed {
        logic [63:0] blk;
        logic        msg_end;
    } t_cipher_entry;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    int            fail_count;
    int            pending_count;
    int            items_sent = 0;
    int            stalled_cycles = 0;
    bit            hold_off_pending = 1'b0;
    bit            send_calm = 1'b0;
    bit            recv_calm = 1'b0;
    t_route        result_routes[$];
    t_cipher_entry ciphertext_pool[$];

    tea_block_cipher_padded dut (.*);

    tea_block_cipher_padded_check chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            i_cfg_we) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles == WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    function automatic t_in_item make_item(input t_cmd cmd, input logic [31:0] high,
                                           input logic [31:0] low, input logic [3:0] count,
                                           input logic last);
        t_in_item item;
        item.command = cmd;
        item.block_high = high;
        item.block_low = low;
        item.byte_count = count;
        item.last = last;
        return item;
    endfunction

    // Pad value p in byte 7 and, for p <= 8, in bytes 8-p..6; optionally one
    // of those bytes spoiled.
    function automatic logic [63:0] craft_pad_block(input int p, input bit corrupt);
        logic [63:0] blk;
        int          k;
        int          pos;
        blk = {$urandom, $urandom};
        blk[63:56] = 8'(p);
        if (p <= BLOCK_BYTES) begin
            for (k = 8 - p; k < 7; k++) begin
                blk[8*k +: 8] = 8'(p);
            end
        end
        if (corrupt && p >= 2 && p <= BLOCK_BYTES) begin
            pos = 8 - $urandom_range(2, p);
            blk[8*pos +: 8] = blk[8*pos +: 8] ^ 8'($urandom_range(1, 255));
        end
        return blk;
    endfunction

    task automatic send_item(input t_in_item item, input logic keep, input logic msg_end);
        int gap;
        if ($urandom_range(0, 23) == 0) begin
            send_calm = !send_calm;
        end
        gap = send_calm ? 0 : $urandom_range(0, WAIT_MAX);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        do @(posedge i_clk); while (!o_in_ready);
        if (item.command == CMD_ENCRYPT && item.last && item.byte_count >= BLOCK_BYTES) begin
            result_routes.push_back({keep, 1'b0});
        end
        result_routes.push_back({keep, msg_end});
        items_sent++;
    endtask

    task automatic drain_block();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_reg idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
    endtask

    task automatic write_keys(input logic [31:0] w0, input logic [31:0] w1,
                              input logic [31:0] w2, input logic [31:0] w3);
        cfg_write(CFG_KEY0, w0);
        cfg_write(CFG_KEY1, w1);
        cfg_write(CFG_KEY2, w2);
        cfg_write(CFG_KEY3, w3);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // output side: random stalls, one long hold-off on request
    initial begin : receiver
        int     stall;
        t_route route;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 23) == 0) begin
                recv_calm = !recv_calm;
            end
            stall = recv_calm ? 0 : $urandom_range(0, WAIT_MAX);
            if (hold_off_pending) begin
                stall = HOLD_OFF_CYCLES;
                hold_off_pending = 1'b0;
            end
            @(negedge i_clk);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if (result_routes.size() != 0) begin
                route = result_routes.pop_front();
                if (route.keep) begin
                    ciphertext_pool.push_back({o_out_data.out_high, o_out_data.out_low,
                                               route.msg_end});
                end
            end
        end
    end

    initial begin : stimulus
        t_in_item      item;
        t_cipher_entry entry;
        int            phase;
        int            phase_goal;
        int            pick;
        int            blocks;
        int            b;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_KEY0;
        i_cfg_data = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // corner blocks under the reset key
        send_item(make_item(CMD_ENCRYPT, 32'h0, 32'h0, 4'd0, 1'b0), 1'b1, 1'b1);
        send_item(make_item(CMD_ENCRYPT, '1, '1, 4'd15, 1'b0), 1'b1, 1'b0);
        send_item(make_item(CMD_ENCRYPT, '1, '1, 4'd0, 1'b1), 1'b1, 1'b1);
        send_item(make_item(CMD_ENCRYPT, '1, '1, 4'd1, 1'b1), 1'b1, 1'b1);
        send_item(make_item(CMD_ENCRYPT, '1, '1, 4'd7, 1'b1), 1'b1, 1'b1);
        send_item(make_item(CMD_ENCRYPT, '1, '1, 4'd8, 1'b1), 1'b1, 1'b1);
        send_item(make_item(CMD_ENCRYPT, 32'h0, 32'h0, 4'd15, 1'b1), 1'b1, 1'b1);
        item = make_item(CMD_ENCRYPT, 32'h0, 32'h0, 4'd0, 1'b0);
        {item.block_high, item.block_low} = craft_pad_block(3, 1'b0);
        send_item(item, 1'b1, 1'b1);
        {item.block_high, item.block_low} = craft_pad_block(5, 1'b1);
        send_item(item, 1'b1, 1'b1);
        {item.block_high, item.block_low} = craft_pad_block(8, 1'b0);
        send_item(item, 1'b1, 1'b1);
        {item.block_high, item.block_low} = craft_pad_block(9, 1'b0);
        send_item(item, 1'b1, 1'b1);
        send_item(make_item(CMD_DECRYPT, 32'h0, 32'h0, 4'd15, 1'b0), 1'b0, 1'b0);
        send_item(make_item(CMD_DECRYPT, '1, '1, 4'd0, 1'b1), 1'b0, 1'b0);
        drain_block();
        while (ciphertext_pool.size() != 0) begin
            entry = ciphertext_pool.pop_front();
            if (entry.msg_end) begin
                send_item(make_item(CMD_DECRYPT, entry.blk[63:32], entry.blk[31:0], 4'd8, 1'b1),
                          1'b0, 1'b0);
            end
        end
        drain_block();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: write_keys('1, '1, '1, '1);
                1: write_keys($urandom, $urandom, $urandom, $urandom);
                2: write_keys(32'h0, '1, 32'h0, '1);
                3: write_keys($urandom, $urandom, $urandom, $urandom);
                default: write_keys(32'h0, 32'h0, 32'h0, 32'h0);
            endcase
            if (phase == 1) begin
                hold_off_pending = 1'b1;
            end
            phase_goal = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < phase_goal) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    // plaintext message; sometimes ends in a crafted pad block
                    blocks = $urandom_range(1, 4);
                    for (b = 1; b <= blocks; b++) begin
                        item = make_item(CMD_ENCRYPT, $urandom, $urandom,
                                         4'($urandom_range(0, 15)), b == blocks);
                        if (b == blocks && $urandom_range(0, 3) == 0) begin
                            {item.block_high, item.block_low} =
                                craft_pad_block($urandom_range(0, 9), $urandom_range(0, 2) == 0);
                            item.last = 1'b0;
                        end
                        send_item(item, 1'b1, b == blocks);
                    end
                end else if (pick < 85 && ciphertext_pool.size() != 0) begin
                    // decrypt one captured message, now and then broken
                    do begin
                        entry = ciphertext_pool.pop_front();
                        item = make_item(CMD_DECRYPT, entry.blk[63:32], entry.blk[31:0],
                                         4'($urandom_range(0, 15)), entry.msg_end);
                        if ($urandom_range(0, 19) == 0) begin
                            item.last = !item.last;
                        end
                        if ($urandom_range(0, 19) == 0) begin
                            {item.block_high, item.block_low} =
                                {item.block_high, item.block_low} ^
                                (64'd1 << $urandom_range(0, 63));
                        end
                        send_item(item, 1'b0, 1'b0);
                    end while (!entry.msg_end && ciphertext_pool.size() != 0);
                end else begin
                    item = make_item($urandom_range(0, 1) ? CMD_DECRYPT : CMD_ENCRYPT,
                                     $urandom, $urandom, 4'($urandom_range(0, 15)),
                                     1'($urandom_range(0, 1)));
                    send_item(item, item.command == CMD_ENCRYPT, item.last);
                end
            end
            drain_block();
            ciphertext_pool.delete();
        end

        if (fail_count == 0 && pending_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/tbcp_pkg.sv
hdl/tbcp_cell.sv
hdl/tbcp_unpad.sv
hdl/tea_block_cipher_padded.sv
tb/tea_block_cipher_padded_check.sv
tb/tea_block_cipher_padded_test.sv
